FILE: rtl/tdc_pkg.sv
// tdc_pkg: shared types, constants and helper functions of the time-of-day clock
// depends on nothing; imported by time_of_day_clock_with_two_alarms and its bench
package tdc_pkg;

	// field widths
	localparam int OP_W      = 3;
	localparam int SEL_W     = 2;
	localparam int BYTE_W    = 8;
	localparam int SEC_W     = 6;
	localparam int HOUR_W    = 5;
	localparam int SEC_BCD_W = 7;
	localparam int HOUR_BCD_W = 6;
	localparam int PRE_W     = 5;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 6;

	// default prescale ratio
	localparam int unsigned TICKS_PER_SECOND_DEF = 20;

	// field tops
	localparam logic [SEC_W-1:0] SEC_TOP  = 6'd59;
	localparam logic [SEC_W-1:0] HOUR_TOP = 6'd23;

	// operation codes
	typedef enum logic [OP_W-1:0] {
		OP_TICK    = 3'd0,
		OP_UP      = 3'd1,
		OP_DOWN    = 3'd2,
		OP_DISMISS = 3'd3,
		OP_LOAD    = 3'd4
	} op_t;

	// field select codes
	localparam logic [SEL_W-1:0] FIELD_SEC  = 2'd0;
	localparam logic [SEL_W-1:0] FIELD_MIN  = 2'd1;
	localparam logic [SEL_W-1:0] FIELD_HOUR = 2'd2;

	// config register indexes
	localparam logic [CFG_IDX_W-1:0] REG_A_SEC  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_A_MIN  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_A_HOUR = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_B_SEC  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_B_MIN  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_B_HOUR = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_ENABLE = 3'd6;

	// one alarm time
	typedef struct packed {
		logic [SEC_W-1:0]  sec;
		logic [SEC_W-1:0]  min;
		logic [HOUR_W-1:0] hour;
	} alarm_t;

	// count up with wrap to zero past top
	function automatic logic [SEC_W-1:0] wrap_up(input logic [SEC_W-1:0] v,
			input logic [SEC_W-1:0] top);
		wrap_up = (v >= top) ? '0 : v + 6'd1;
	endfunction

	// count down with wrap to top below zero or when out of range
	function automatic logic [SEC_W-1:0] wrap_down(input logic [SEC_W-1:0] v,
			input logic [SEC_W-1:0] top);
		wrap_down = (v == '0 || v > top) ? top : v - 6'd1;
	endfunction

	// two nibbles to binary, clamped to top
	function automatic logic [SEC_W-1:0] bcd_to_bin(input logic [BYTE_W-1:0] b,
			input logic [SEC_W-1:0] top);
		logic [BYTE_W-1:0] v;
		v = ({4'd0, b[7:4]} << 3) + ({4'd0, b[7:4]} << 1) + {4'd0, b[3:0]};
		bcd_to_bin = (v > {2'd0, top}) ? top : v[SEC_W-1:0];
	endfunction

	// binary 0..63 to two bcd digits, tens found by a row of compares
	function automatic logic [SEC_BCD_W-1:0] bin_to_bcd(input logic [SEC_W-1:0] v);
		logic [2:0] tens;
		logic [SEC_W-1:0] ones;
		tens = '0;
		for (int k = 1; k <= 6; k++) begin
			if (v >= SEC_W'(10 * k))
				tens = 3'(k);
		end
		ones = v - ({3'd0, tens} << 3) - ({3'd0, tens} << 1);
		bin_to_bcd = {tens, ones[3:0]};
	endfunction

endpackage

FILE: rtl/time_of_day_clock_with_two_alarms.sv
// time_of_day_clock_with_two_alarms: 24-hour clock with tick prescaler and two alarms
// depends on tdc_pkg (types, codes and conversion functions)
//
// Usage:
//   Input words (op, field_select, load_*_bcd) enter on in_valid / in_stall; each word
//   produces exactly one result word on out_valid / out_stall with the time in binary
//   and BCD and the ringing flag, all taken after the word's update.
//   out_valid rises once a word has passed the input register and then the state update
//   and BCD conversion into the result register. Throughput is one word per cycle while
//   the receiver does not stall; the state registers are read and written in the same
//   cycle so the next word sees the update without bubbles.
//   When the receiver stalls, the result register holds, the input register fills,
//   and then in_stall rises until the result is taken.
//   The user writes alarm registers through cfg_wr_en / cfg_index / cfg_data while no
//   word is in flight, unenforced by the block. Indexes past the list are ignored.
//   Reset clears the time, prescaler and ringing flag, sets both alarms to 01:01:01
//   and disables them; both pipeline stages come up empty.
module time_of_day_clock_with_two_alarms #(
	parameter int unsigned TICKS_PER_SECOND = tdc_pkg::TICKS_PER_SECOND_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// config write port
	input  logic                              cfg_wr_en,
	input  logic [tdc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [tdc_pkg::CFG_DAT_W-1:0]     cfg_data,
	// input channel
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [tdc_pkg::OP_W-1:0]          op,
	input  logic [tdc_pkg::SEL_W-1:0]         field_select,
	input  logic [tdc_pkg::BYTE_W-1:0]        load_second_bcd,
	input  logic [tdc_pkg::BYTE_W-1:0]        load_minute_bcd,
	input  logic [tdc_pkg::BYTE_W-1:0]        load_hour_bcd,
	// result channel
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [tdc_pkg::SEC_W-1:0]         second_now,
	output logic [tdc_pkg::SEC_W-1:0]         minute_now,
	output logic [tdc_pkg::HOUR_W-1:0]        hour_now,
	output logic [tdc_pkg::SEC_BCD_W-1:0]     second_bcd,
	output logic [tdc_pkg::SEC_BCD_W-1:0]     minute_bcd,
	output logic [tdc_pkg::HOUR_BCD_W-1:0]    hour_bcd,
	output logic                              ringing
);
	import tdc_pkg::*;

	localparam logic [PRE_W:0] TPS = (PRE_W + 1)'(TICKS_PER_SECOND);

	// config registers
	alarm_t alarm_a_q, alarm_b_q;
	logic   alarm_en_q;

	// clock state
	logic [PRE_W-1:0]  pre_q;
	logic [SEC_W-1:0]  sec_q, min_q;
	logic [HOUR_W-1:0] hour_q;
	logic              ring_q;

	// input stage
	logic              valid_s1;
	logic [OP_W-1:0]   op_s1;
	logic [SEL_W-1:0]  sel_s1;
	logic [BYTE_W-1:0] ld_sec_s1, ld_min_s1, ld_hour_s1;

	// result stage
	logic                  out_valid_q;
	logic [SEC_W-1:0]      sec_out_q, min_out_q;
	logic [HOUR_W-1:0]     hour_out_q;
	logic [SEC_BCD_W-1:0]  sec_bcd_q, min_bcd_q;
	logic [HOUR_BCD_W-1:0] hour_bcd_q;
	logic                  ring_out_q;

	// next state
	logic [PRE_W-1:0]  pre_nx;
	logic [SEC_W-1:0]  sec_nx, min_nx, hour_nx;
	logic              ring_nx;
	logic [PRE_W:0]    pre_inc;
	logic [SEC_W-1:0]  hour_w, sec_adv, min_adv, hour_adv;
	logic [SEC_BCD_W-1:0] hour_bcd_w;
	logic              hit_a, hit_b;
	logic              advance;

	// pipeline moves when the result register is empty or being taken
	assign advance  = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !advance;

	// config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alarm_a_q  <= '{sec: 6'd1, min: 6'd1, hour: 5'd1};
			alarm_b_q  <= '{sec: 6'd1, min: 6'd1, hour: 5'd1};
			alarm_en_q <= 1'b0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_A_SEC:  alarm_a_q.sec  <= cfg_data;
				REG_A_MIN:  alarm_a_q.min  <= cfg_data;
				REG_A_HOUR: alarm_a_q.hour <= cfg_data[HOUR_W-1:0];
				REG_B_SEC:  alarm_b_q.sec  <= cfg_data;
				REG_B_MIN:  alarm_b_q.min  <= cfg_data;
				REG_B_HOUR: alarm_b_q.hour <= cfg_data[HOUR_W-1:0];
				REG_ENABLE: alarm_en_q     <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			op_s1      <= op;
			sel_s1     <= field_select;
			ld_sec_s1  <= load_second_bcd;
			ld_min_s1  <= load_minute_bcd;
			ld_hour_s1 <= load_hour_bcd;
		end
	end

	// seconds carry chain for a tick that rolls the prescaler
	assign hour_w  = {1'b0, hour_q};
	assign pre_inc = {1'b0, pre_q} + 6'd1;
	always_comb begin
		sec_adv  = wrap_up(sec_q, SEC_TOP);
		min_adv  = min_q;
		hour_adv = hour_w;
		if (sec_adv == '0) begin
			min_adv = wrap_up(min_q, SEC_TOP);
			if (min_adv == '0)
				hour_adv = wrap_up(hour_w, HOUR_TOP);
		end
	end

	// alarm compare against the advanced time
	assign hit_a = hour_adv == {1'b0, alarm_a_q.hour} && min_adv == alarm_a_q.min &&
		sec_adv == alarm_a_q.sec;
	assign hit_b = hour_adv == {1'b0, alarm_b_q.hour} && min_adv == alarm_b_q.min &&
		sec_adv == alarm_b_q.sec;

	// per-op state update
	always_comb begin
		pre_nx  = pre_q;
		sec_nx  = sec_q;
		min_nx  = min_q;
		hour_nx = hour_w;
		ring_nx = ring_q;
		case (op_t'(op_s1))
			OP_TICK: begin
				if (pre_inc >= TPS) begin
					pre_nx  = '0;
					sec_nx  = sec_adv;
					min_nx  = min_adv;
					hour_nx = hour_adv;
					if (alarm_en_q && (hit_a || hit_b))
						ring_nx = 1'b1;
				end else begin
					pre_nx = pre_inc[PRE_W-1:0];
				end
			end
			OP_UP: begin
				case (sel_s1)
					FIELD_SEC:  sec_nx  = wrap_up(sec_q, SEC_TOP);
					FIELD_MIN:  min_nx  = wrap_up(min_q, SEC_TOP);
					FIELD_HOUR: hour_nx = wrap_up(hour_w, HOUR_TOP);
					default: ;
				endcase
			end
			OP_DOWN: begin
				case (sel_s1)
					FIELD_SEC:  sec_nx  = wrap_down(sec_q, SEC_TOP);
					FIELD_MIN:  min_nx  = wrap_down(min_q, SEC_TOP);
					FIELD_HOUR: hour_nx = wrap_down(hour_w, HOUR_TOP);
					default: ;
				endcase
			end
			OP_DISMISS: begin
				ring_nx = 1'b0;
			end
			OP_LOAD: begin
				sec_nx  = bcd_to_bin(ld_sec_s1, SEC_TOP);
				min_nx  = bcd_to_bin(ld_min_s1, SEC_TOP);
				hour_nx = bcd_to_bin(ld_hour_s1, HOUR_TOP);
			end
			default: ;
		endcase
	end

	// state registers, updated as each word passes the input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pre_q  <= '0;
			sec_q  <= '0;
			min_q  <= '0;
			hour_q <= '0;
			ring_q <= 1'b0;
		end else if (valid_s1 && advance) begin
			pre_q  <= pre_nx;
			sec_q  <= sec_nx;
			min_q  <= min_nx;
			hour_q <= hour_nx[HOUR_W-1:0];
			ring_q <= ring_nx;
		end
	end

	// result register
	assign hour_bcd_w = bin_to_bcd(hour_nx);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && advance) begin
			sec_out_q  <= sec_nx;
			min_out_q  <= min_nx;
			hour_out_q <= hour_nx[HOUR_W-1:0];
			sec_bcd_q  <= bin_to_bcd(sec_nx);
			min_bcd_q  <= bin_to_bcd(min_nx);
			hour_bcd_q <= hour_bcd_w[HOUR_BCD_W-1:0];
			ring_out_q <= ring_nx;
		end
	end

	assign out_valid  = out_valid_q;
	assign second_now = sec_out_q;
	assign minute_now = min_out_q;
	assign hour_now   = hour_out_q;
	assign second_bcd = sec_bcd_q;
	assign minute_bcd = min_bcd_q;
	assign hour_bcd   = hour_bcd_q;
	assign ringing    = ring_out_q;

endmodule

FILE: tb/tb_time_of_day_clock_with_two_alarms.sv
// tb_time_of_day_clock_with_two_alarms: self-checking bench for the two-alarm time-of-day clock
// holds a word-level predictor in a small scoreboard class, stimulus tasks and handshake drivers
// depends on tdc_pkg and rtl/time_of_day_clock_with_two_alarms.sv
module tb_time_of_day_clock_with_two_alarms;
	timeunit 1ns;
	timeprecision 1ps;

	import tdc_pkg::*;

	localparam int TICKS     = TICKS_PER_SECOND_DEF;
	localparam int LIMIT     = 400000;
	localparam int SETTLE    = 6;
	localparam int PHASE_LEN = 200;
	localparam int MAX_SHOWN = 10;
	localparam int DAY_SECS  = 86400;

	// codes the package leaves unnamed
	localparam logic [SEL_W-1:0]     FIELD_NONE = 2'd3;
	localparam logic [CFG_IDX_W-1:0] REG_NONE   = 3'd7;

	// one result word as the block shows it
	typedef struct packed {
		logic [SEC_W-1:0]      sec;
		logic [SEC_W-1:0]      min;
		logic [HOUR_W-1:0]     hour;
		logic [SEC_BCD_W-1:0]  sec_bcd;
		logic [SEC_BCD_W-1:0]  min_bcd;
		logic [HOUR_BCD_W-1:0] hour_bcd;
		logic                  ring;
	} clock_view_t;

	// predicts the clock state per accepted word and checks result words in order
	class alarm_clock_board;
		int            prescale;
		int            sec, min, hour;
		bit            latched;
		alarm_t        alarm_a, alarm_b;
		bit            alarm_on;
		clock_view_t   views_due[$];
		int            mismatches;
		int            results_seen;
		int            rings;

		function new();
			prescale = 0;
			sec = 0;
			min = 0;
			hour = 0;
			latched = 0;
			alarm_a = '{sec: 6'd1, min: 6'd1, hour: 5'd1};
			alarm_b = '{sec: 6'd1, min: 6'd1, hour: 5'd1};
			alarm_on = 0;
			mismatches = 0;
			results_seen = 0;
			rings = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
			case (idx)
				REG_A_SEC:  alarm_a.sec = val;
				REG_A_MIN:  alarm_a.min = val;
				REG_A_HOUR: alarm_a.hour = val[HOUR_W-1:0];
				REG_B_SEC:  alarm_b.sec = val;
				REG_B_MIN:  alarm_b.min = val;
				REG_B_HOUR: alarm_b.hour = val[HOUR_W-1:0];
				REG_ENABLE: alarm_on = val[0];
				default: ;
			endcase
		endfunction

		function int count_up(int v, int top);
			return (v >= top) ? 0 : v + 1;
		endfunction

		function int count_down(int v, int top);
			return (v == 0 || v > top) ? top : v - 1;
		endfunction

		// two nibbles, each taken at face value, then clamped
		function int from_bcd(logic [BYTE_W-1:0] b, int top);
			int v;
			v = int'(b[7:4]) * 10 + int'(b[3:0]);
			return (v > top) ? top : v;
		endfunction

		function logic [BYTE_W-1:0] to_bcd(int v);
			return BYTE_W'((v / 10) * 16 + (v % 10));
		endfunction

		function bit hits(alarm_t a);
			return hour == int'(a.hour) && min == int'(a.min) && sec == int'(a.sec);
		endfunction

		// seconds carry chain; only this path can latch the ring
		function void next_second();
			sec = count_up(sec, 59);
			if (sec == 0) begin
				min = count_up(min, 59);
				if (min == 0)
					hour = count_up(hour, 23);
			end
			if (alarm_on && (hits(alarm_a) || hits(alarm_b))) begin
				if (!latched)
					rings++;
				latched = 1;
			end
		endfunction

		// update state for one accepted word and queue the view it causes
		function void apply_word(logic [OP_W-1:0] code, logic [SEL_W-1:0] sel,
				logic [BYTE_W-1:0] s_b, logic [BYTE_W-1:0] m_b, logic [BYTE_W-1:0] h_b);
			clock_view_t v;
			case (code)
				OP_TICK: begin
					if (prescale + 1 >= TICKS) begin
						prescale = 0;
						next_second();
					end else begin
						prescale = prescale + 1;
					end
				end
				OP_UP, OP_DOWN: begin
					if (sel == FIELD_SEC)
						sec = (code == OP_UP) ? count_up(sec, 59) : count_down(sec, 59);
					else if (sel == FIELD_MIN)
						min = (code == OP_UP) ? count_up(min, 59) : count_down(min, 59);
					else if (sel == FIELD_HOUR)
						hour = (code == OP_UP) ? count_up(hour, 23) : count_down(hour, 23);
				end
				OP_DISMISS: latched = 0;
				OP_LOAD: begin
					sec = from_bcd(s_b, 59);
					min = from_bcd(m_b, 59);
					hour = from_bcd(h_b, 23);
				end
				default: ;
			endcase
			v.sec = SEC_W'(sec);
			v.min = SEC_W'(min);
			v.hour = HOUR_W'(hour);
			v.sec_bcd = SEC_BCD_W'(to_bcd(sec));
			v.min_bcd = SEC_BCD_W'(to_bcd(min));
			v.hour_bcd = HOUR_BCD_W'(to_bcd(hour));
			v.ring = latched;
			views_due.push_back(v);
		endfunction

		function void compare_field(string name, int want, int got);
			if (want != got) begin
				mismatches++;
				if (mismatches <= MAX_SHOWN)
					$display("mismatch in %s of result %0d: expected %0d, got %0d",
						name, results_seen, want, got);
			end
		endfunction

		function void check_view(clock_view_t got);
			clock_view_t want;
			results_seen++;
			if (views_due.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_SHOWN)
					$display("unexpected result %0d: %0d:%0d:%0d ring %0d", results_seen,
						got.hour, got.min, got.sec, got.ring);
				return;
			end
			want = views_due.pop_front();
			compare_field("second_now", want.sec, got.sec);
			compare_field("minute_now", want.min, got.min);
			compare_field("hour_now", want.hour, got.hour);
			compare_field("second_bcd", want.sec_bcd, got.sec_bcd);
			compare_field("minute_bcd", want.min_bcd, got.min_bcd);
			compare_field("hour_bcd", want.hour_bcd, got.hour_bcd);
			compare_field("ringing", want.ring, got.ring);
		endfunction

		function int pending();
			return views_due.size();
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_wr_en;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DAT_W-1:0]  cfg_data;
	logic                  in_valid;
	logic                  in_stall;
	logic [OP_W-1:0]       op;
	logic [SEL_W-1:0]      field_select;
	logic [BYTE_W-1:0]     load_second_bcd;
	logic [BYTE_W-1:0]     load_minute_bcd;
	logic [BYTE_W-1:0]     load_hour_bcd;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic [SEC_W-1:0]      second_now;
	logic [SEC_W-1:0]      minute_now;
	logic [HOUR_W-1:0]     hour_now;
	logic [SEC_BCD_W-1:0]  second_bcd;
	logic [SEC_BCD_W-1:0]  minute_bcd;
	logic [HOUR_BCD_W-1:0] hour_bcd;
	logic                  ringing;

	alarm_clock_board board;
	int sender_idle_pct;
	int receiver_stall_pct;
	int words_sent;
	int cycles = 0;
	int settings_used;

	time_of_day_clock_with_two_alarms #(
		.TICKS_PER_SECOND(TICKS)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.op(op),
		.field_select(field_select),
		.load_second_bcd(load_second_bcd),
		.load_minute_bcd(load_minute_bcd),
		.load_hour_bcd(load_hour_bcd),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.second_now(second_now),
		.minute_now(minute_now),
		.hour_now(hour_now),
		.second_bcd(second_bcd),
		.minute_bcd(minute_bcd),
		.hour_bcd(hour_bcd),
		.ringing(ringing)
	);

	// 20 ns clock
	initial clk = 1'b0;
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("tb_time_of_day_clock_with_two_alarms: done, errors");
			$finish;
		end
	end

	// receiver stalls at random
	always @(posedge clk) begin
		out_stall <= ($urandom_range(0, 99) < receiver_stall_pct);
	end

	// take each accepted result word to the scoreboard
	always @(posedge clk) begin : result_monitor
		clock_view_t got;
		got = {second_now, minute_now, hour_now, second_bcd, minute_bcd, hour_bcd, ringing};
		if (arst_n && out_valid && !out_stall)
			board.check_view(got);
	end

	// offer one word, hold it through stalls, note it once accepted
	task automatic send_word(logic [OP_W-1:0] code, logic [SEL_W-1:0] sel,
			logic [BYTE_W-1:0] s_b, logic [BYTE_W-1:0] m_b, logic [BYTE_W-1:0] h_b);
		while ($urandom_range(0, 99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		op <= code;
		field_select <= sel;
		load_second_bcd <= s_b;
		load_minute_bcd <= m_b;
		load_hour_bcd <= h_b;
		do
			@(posedge clk);
		while (in_stall);
		board.apply_word(code, sel, s_b, m_b, h_b);
		words_sent++;
	endtask

	// a word whose load bytes do not matter
	task automatic send_plain(logic [OP_W-1:0] code, logic [SEL_W-1:0] sel);
		send_word(code, sel, BYTE_W'($urandom_range(0, 255)), BYTE_W'($urandom_range(0, 255)),
			BYTE_W'($urandom_range(0, 255)));
	endtask

	task automatic send_noise();
		send_plain(OP_W'($urandom_range(0, 7)), SEL_W'($urandom_range(0, 3)));
	endtask

	// wait until every result is back and the pipeline is empty
	task automatic drain();
		in_valid <= 1'b0;
		while (board.pending() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		board.set_reg(idx, val);
	endtask

	task automatic cfg_done();
		cfg_wr_en <= 1'b0;
		@(posedge clk);
	endtask

	task automatic program_alarms(alarm_t a, alarm_t b, bit en);
		write_reg(REG_A_SEC, a.sec);
		write_reg(REG_A_MIN, a.min);
		write_reg(REG_A_HOUR, CFG_DAT_W'(a.hour));
		write_reg(REG_B_SEC, b.sec);
		write_reg(REG_B_MIN, b.min);
		write_reg(REG_B_HOUR, CFG_DAT_W'(b.hour));
		write_reg(REG_ENABLE, CFG_DAT_W'(en));
		cfg_done();
		settings_used++;
	endtask

	function automatic alarm_t random_alarm();
		alarm_t a;
		a.sec = SEC_W'($urandom_range(0, 59));
		a.min = SEC_W'($urandom_range(0, 59));
		a.hour = HOUR_W'($urandom_range(0, 23));
		return a;
	endfunction

	// load a time at or one second short of alarm a, alarm b or a random time, then tick past it
	task automatic alarm_run();
		alarm_t target;
		int pick, lead, t, n;
		pick = $urandom_range(0, 2);
		target = (pick == 0) ? board.alarm_a : (pick == 1) ? board.alarm_b : random_alarm();
		if (target.sec > 59 || target.min > 59 || target.hour > 23)
			target = random_alarm();
		lead = $urandom_range(0, 1);
		t = (int'(target.hour) * 3600 + int'(target.min) * 60 + int'(target.sec) - lead
			+ DAY_SECS) % DAY_SECS;
		send_word(OP_LOAD, SEL_W'($urandom_range(0, 3)), board.to_bcd(t % 60),
			board.to_bcd((t / 60) % 60), board.to_bcd(t / 3600));
		n = TICKS * (lead + 1) + $urandom_range(0, 4);
		repeat (n) send_plain(OP_TICK, SEL_W'($urandom_range(0, 3)));
		if ($urandom_range(0, 99) < 30)
			send_plain($urandom_range(0, 1) ? OP_UP : OP_DOWN, SEL_W'($urandom_range(0, 3)));
		if ($urandom_range(0, 99) < 60)
			send_plain(OP_DISMISS, SEL_W'($urandom_range(0, 3)));
	endtask

	task automatic random_phase(int idle_pct, int stall_pct);
		int stop_at;
		sender_idle_pct = idle_pct;
		receiver_stall_pct = stall_pct;
		stop_at = words_sent + PHASE_LEN;
		while (words_sent < stop_at) begin
			if ($urandom_range(0, 99) < 70)
				alarm_run();
			else
				repeat ($urandom_range(1, 6)) send_noise();
		end
		drain();
	endtask

	// main sequence
	initial begin
		alarm_t a_cfg, b_cfg;
		board = new();
		words_sent = 0;
		settings_used = 0;
		sender_idle_pct = 15;
		receiver_stall_pct = 77;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		op = OP_TICK;
		field_select = FIELD_SEC;
		load_second_bcd = '0;
		load_minute_bcd = '0;
		load_hour_bcd = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// unused codes and a bad field select, still at reset settings
		for (int c = int'(OP_LOAD) + 1; c < 8; c++)
			send_plain(OP_W'(c), FIELD_SEC);
		send_plain(OP_UP, FIELD_NONE);
		send_plain(OP_DOWN, FIELD_NONE);
		drain();

		// alarm a out of range at the top of each width, alarm b at midnight
		a_cfg = '{sec: 6'h3f, min: 6'h3f, hour: 5'h1f};
		b_cfg = '{sec: 6'd0, min: 6'd0, hour: 5'd0};
		write_reg(REG_NONE, CFG_DAT_W'($urandom_range(0, 63)));
		program_alarms(a_cfg, b_cfg, 1'b1);

		// steps wrap at both ends and do not ring on reaching the alarm time
		send_plain(OP_DOWN, FIELD_SEC);
		send_plain(OP_DOWN, FIELD_MIN);
		send_plain(OP_DOWN, FIELD_HOUR);
		send_plain(OP_UP, FIELD_SEC);
		send_plain(OP_UP, FIELD_MIN);
		send_plain(OP_UP, FIELD_HOUR);
		// loads: nibbles above nine, clamping, exact tops
		send_word(OP_LOAD, FIELD_SEC, 8'h9a, 8'h1f, 8'h1f);
		send_word(OP_LOAD, FIELD_SEC, 8'h59, 8'h59, 8'h23);
		send_word(OP_LOAD, FIELD_SEC, 8'hff, 8'hff, 8'hff);
		send_plain(OP_DISMISS, FIELD_SEC);
		// one full prescale count carries 23:59:59 into midnight and rings
		repeat (TICKS) send_plain(OP_TICK, FIELD_SEC);
		send_plain(OP_UP, FIELD_SEC);
		send_plain(OP_DOWN, FIELD_SEC);
		drain();

		// disabling while ringing leaves the ring on until dismissed
		write_reg(REG_ENABLE, CFG_DAT_W'(0));
		cfg_done();
		send_word(OP_LOAD, FIELD_SEC, 8'h00, 8'h00, 8'h00);
		send_plain(OP_TICK, FIELD_SEC);
		send_plain(OP_DISMISS, FIELD_SEC);
		send_plain(OP_DISMISS, FIELD_SEC);
		drain();

		// random phases under different alarm settings and idling mixes
		b_cfg = '{sec: 6'd59, min: 6'd59, hour: 5'd23};
		program_alarms(random_alarm(), b_cfg, 1'b1);
		random_phase(15, 77);

		b_cfg = random_alarm();
		b_cfg.sec = SEC_W'($urandom_range(60, 63));
		program_alarms(random_alarm(), b_cfg, 1'b1);
		random_phase(77, 15);

		program_alarms(random_alarm(), random_alarm(), 1'b1);
		random_phase(0, 0);

		$display("covered %0d input words and %0d result words over %0d alarm settings",
			words_sent, board.results_seen, settings_used);
		$display("alarm latches predicted %0d, field mismatches %0d, results still owed %0d",
			board.rings, board.mismatches, board.pending());
		if (board.mismatches == 0 && board.pending() == 0)
			$display("tb_time_of_day_clock_with_two_alarms: done, clean");
		else
			$display("tb_time_of_day_clock_with_two_alarms: done, errors");
		$finish;
	end

endmodule
